@@ design/sfs_pkg.sv @@
package sfs_pkg;

    // default tile size in texels
    localparam int TILE_WIDTH_DEF  = 32;
    localparam int TILE_HEIGHT_DEF = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LAST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd6;

    // field widths
    localparam int CFG_DATA_W = 9;
    localparam int FRAME_W    = 8;
    localparam int TEXEL_W    = 16;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } seq_state_t;

endpackage

@@ design/sfs_div.sv @@
module sfs_div
    import sfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [FRAME_W-1:0]    dividend,
    input  logic [CFG_DATA_W-1:0] divisor,
    output logic                  done,
    output logic [FRAME_W-1:0]    quotient,
    output logic [FRAME_W-1:0]    remainder
);

    localparam int StepW = $clog2(FRAME_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [StepW-1:0]      step_reg, step_next;
    logic [CFG_DATA_W-1:0] rem_reg, rem_next;
    logic [FRAME_W-1:0]    quo_reg, quo_next;
    logic [CFG_DATA_W:0]   trial;
    logic [CFG_DATA_W:0]   diff;
    logic                  fits;

    // one restoring step: shift in the next dividend bit and try the subtract
    always_comb begin
        trial = {rem_reg, quo_reg[FRAME_W-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});
    end

    // step sequencing
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = StepW'(FRAME_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? diff[CFG_DATA_W-1:0] : trial[CFG_DATA_W-1:0];
            quo_next = {quo_reg[FRAME_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[FRAME_W-1:0];

endmodule

@@ design/sprite_frame_sequencer_unit.sv @@
// an accepted tick word runs through the 8-step restoring divider, which splits
// the frame index into grid column and row, and then waits in ST_OUT for the
// result register; no new tick word is taken until the result is loaded
// the result register lets the next tick be accepted while a result waits
// reset: synchronous active-low aresetn clears counter, frame, done flag and
// handshake state, and loads the configuration register defaults
module sprite_frame_sequencer_unit
    import sfs_pkg::*;
#(
    parameter int TILE_WIDTH  = TILE_WIDTH_DEF,
    parameter int TILE_HEIGHT = TILE_HEIGHT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // tick channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_tick_valid,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FRAME_W-1:0]    m_frame_index,
    output logic                  m_done_flag,
    output logic [TEXEL_W-1:0]    m_texel_x,
    output logic [TEXEL_W-1:0]    m_texel_y
);

    localparam int TileSzW = CFG_DATA_W;
    localparam int ProdW   = FRAME_W + TileSzW;
    localparam logic [TileSzW-1:0] TileW = TileSzW'(TILE_WIDTH);
    localparam logic [TileSzW-1:0] TileH = TileSzW'(TILE_HEIGHT);

    // configuration registers
    logic signed [CFG_DATA_W-1:0] frame_period_reg;
    logic                         loop_enable_reg;
    logic [CFG_DATA_W-1:0]        frame_count_reg;
    logic signed [CFG_DATA_W-1:0] range_first_reg;
    logic signed [CFG_DATA_W-1:0] range_last_reg;
    logic [CFG_DATA_W-1:0]        grid_columns_reg;
    logic [CFG_DATA_W-1:0]        grid_rows_reg;

    // animation state
    logic [FRAME_W-1:0] tick_counter_reg, tick_counter_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               done_reg, done_next;

    // sequencer and result register
    seq_state_t         state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic [FRAME_W-1:0] m_frame_reg;
    logic               m_done_reg;
    logic [TEXEL_W-1:0] m_tx_reg, m_ty_reg;

    logic               s_accept;
    logic               out_load;
    logic               div_done;
    logic [FRAME_W-1:0] div_quo, div_rem;

    // frame step signals
    logic                   running;
    logic [FRAME_W:0]       tick_inc;
    logic                   ranged;
    logic signed [9:0]      last_raw, last_sat, cur_s, cur_inc, start_s, adv_frame;
    logic                   adv_done;
    logic                   in_grid;
    logic [ProdW-1:0]       prod_x, prod_y;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_period_reg <= '0;
            loop_enable_reg  <= 1'b0;
            frame_count_reg  <= '0;
            range_first_reg  <= '1;
            range_last_reg   <= '1;
            grid_columns_reg <= CFG_DATA_W'(1);
            grid_rows_reg    <= CFG_DATA_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FRAME_PERIOD: frame_period_reg <= cfg_data;
                CFG_LOOP_ENABLE:  loop_enable_reg  <= cfg_data[0];
                CFG_FRAME_COUNT:  frame_count_reg  <= cfg_data;
                CFG_RANGE_FIRST:  range_first_reg  <= cfg_data;
                CFG_RANGE_LAST:   range_last_reg   <= cfg_data;
                CFG_GRID_COLUMNS: grid_columns_reg <= cfg_data;
                CFG_GRID_ROWS:    grid_rows_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // frame advance: start, saturated last frame, loop wrap or one-shot clamp
    always_comb begin
        ranged   = !range_first_reg[CFG_DATA_W-1] && !range_last_reg[CFG_DATA_W-1];
        start_s  = ranged ? {2'b00, range_first_reg[FRAME_W-1:0]} : '0;
        last_raw = ranged ? {2'b00, range_last_reg[FRAME_W-1:0]}
                          : $signed({1'b0, frame_count_reg}) - 10'sd1;
        last_sat = (last_raw > 10'sd255) ? 10'sd255 : last_raw;
        cur_s    = {2'b00, frame_reg};
        cur_inc  = cur_s + 10'sd1;
        adv_done = 1'b0;
        if (loop_enable_reg) begin
            adv_frame = (last_sat <= cur_s) ? start_s : cur_inc;
            adv_done  = (adv_frame == start_s);
        end else begin
            adv_frame = cur_inc;
            if (last_sat < cur_inc) begin
                adv_frame = last_sat[9] ? 10'sd0 : last_sat;
                adv_done  = 1'b1;
            end
        end
    end

    // prescaler and state update on an accepted tick word
    always_comb begin
        running  = s_tick_valid && !frame_period_reg[CFG_DATA_W-1]
                   && !(!loop_enable_reg && done_reg);
        tick_inc = {1'b0, tick_counter_reg} + 1'b1;
        tick_counter_next = tick_counter_reg;
        frame_next        = frame_reg;
        done_next         = done_reg;
        if (s_accept && running) begin
            if (tick_inc < {1'b0, frame_period_reg[FRAME_W-1:0]}) begin
                tick_counter_next = tick_inc[FRAME_W-1:0];
                done_next         = 1'b0;
            end else begin
                tick_counter_next = '0;
                frame_next        = adv_frame[FRAME_W-1:0];
                done_next         = adv_done;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_counter_reg <= '0;
            frame_reg        <= '0;
            done_reg         <= 1'b0;
        end else begin
            tick_counter_reg <= tick_counter_next;
            frame_reg        <= frame_next;
            done_reg         <= done_next;
        end
    end

    // frame index split into column (remainder) and row (quotient)
    sfs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_accept),
        .dividend  (frame_next),
        .divisor   (grid_columns_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // tile origin: frame beyond the grid or zero columns gives zero, row below rows means inside
    always_comb begin
        in_grid = (grid_columns_reg != '0) && ({1'b0, div_quo} < grid_rows_reg);
        prod_x  = {{TileSzW{1'b0}}, div_rem} * {{FRAME_W{1'b0}}, TileW};
        prod_y  = {{TileSzW{1'b0}}, div_quo} * {{FRAME_W{1'b0}}, TileH};
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_frame_reg <= frame_reg;
            m_done_reg  <= done_reg;
            m_tx_reg    <= in_grid ? prod_x[TEXEL_W-1:0] : '0;
            m_ty_reg    <= in_grid ? prod_y[TEXEL_W-1:0] : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_frame_index = m_frame_reg;
    assign m_done_flag   = m_done_reg;
    assign m_texel_x     = m_tx_reg;
    assign m_texel_y     = m_ty_reg;

endmodule

@@ design/sfs_checker.sv @@
module sfs_checker
    import sfs_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [FRAME_W-1:0]    m_frame_index,
    input logic                  m_done_flag
);

    // reset leaves no word pending on the result side
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // configuration writes are never refused
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    // a tick word in flight blocks the next one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("tick accepted while busy");

    // a new result only appears after a tick word was taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result without a tick word");

    // stalled result word stays valid and holds its frame index and done flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_frame_index)
                                  && $stable(m_done_flag))
        else $error("stalled result word changed");

endmodule

bind sprite_frame_sequencer_unit sfs_checker u_sfs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_frame_index (m_frame_index),
    .m_done_flag   (m_done_flag)
);
